### rtl/slist_pkg.sv
// package for the sorted list insert/remove core
// holds operation kinds, status codes, controller states and the default capacity
// no dependencies
package slist_pkg;

   localparam int SLIST_CAPACITY = 16;
   localparam int VALUE_W        = 32;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_SHOW   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_REM_CMP,
      ST_SHOW_RD,
      ST_SHOW_OUT,
      ST_REPLY
   } state_type;

endpackage

### rtl/slist_ram.sv
// single-port-write, single-port-read memory holding the list entries
// read data is registered and held until the next read; uses slist_pkg defaults
module slist_ram
   import slist_pkg::*;
#(
   parameter int DEPTH = SLIST_CAPACITY,
   parameter int WIDTH = VALUE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sorted_list_insert_remove_core.sv
// top level of the sorted list core: controller, entry count and result register
// depends on slist_pkg and slist_ram
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in one memory
// with a registered read port. One request is worked on at a time. An insert
// walks down from the top entry, moving every entry that is >= the new value up
// by one slot, one entry per cycle, then drops the value into the gap. On an
// empty list the value goes straight into slot zero, and on a full list the
// insert is refused. A remove reads every entry once from the bottom and closes
// the gap behind the first match. A show reads each entry and then loads it
// into the result register (read, then load of the result register), waiting
// while that register still holds an untaken result; an empty list gives one
// result. The single memory read port is why the walks visit entries one by one.
// The result register lets the next request in while the last result of the
// previous one still waits for the consumer. Unused kind codes are taken and give no result.
module sorted_list_insert_remove_core
   import slist_pkg::*;
#(
   parameter int CAPACITY = SLIST_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] item, [33:32] status, zero above
   output logic        rsp_tlast    // last result of the request
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // controller state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               found_ff, found_in;
   status_type         status_ff, status_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_item_ff, rsp_item_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   // memory port
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [VALUE_W-1:0] ram_wdata;
   logic               ram_re;
   logic [IDX_W-1:0]   ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;

   logic               accept;
   logic               out_free;
   logic               rsp_load;
   logic [CNT_W-1:0]   count_dec;
   logic [IDX_W-1:0]   last_idx;
   logic [IDX_W-1:0]   idx_inc;
   logic [IDX_W-1:0]   idx_dec;
   logic               list_full;
   logic               list_empty;
   logic               at_last;
   logic               rd_ge;
   logic               rd_eq;
   kind_type           req_kind;

   slist_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_kind   = kind_type'(req_tuser);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign count_dec  = count_ff - CNT_W'(1);
   assign last_idx   = count_dec[IDX_W-1:0];
   assign idx_inc    = idx_ff + IDX_W'(1);
   assign idx_dec    = idx_ff - IDX_W'(1);
   assign list_full  = (count_ff == CNT_W'(CAPACITY));
   assign list_empty = (count_ff == '0);
   assign at_last    = (idx_ff == last_idx);

   // signed compares against the entry just read
   assign rd_ge = ($signed(ram_rdata) >= $signed(value_ff));
   assign rd_eq = (ram_rdata == value_ff);

   // next state and working registers
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      status_in = status_ff;
      value_in  = value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_tdata;
               found_in = 1'b0;
               case (req_kind)
                  KIND_INSERT: begin
                     if (list_full) begin
                        status_in = STAT_FULL;
                        state_in  = ST_REPLY;
                     end else if (list_empty) begin
                        // first entry goes straight into slot zero
                        count_in  = count_ff + CNT_W'(1);
                        status_in = STAT_OK;
                        state_in  = ST_REPLY;
                     end else begin
                        idx_in   = last_idx;
                        state_in = ST_INS_CMP;
                     end
                  end
                  KIND_REMOVE: begin
                     if (list_empty) begin
                        status_in = STAT_NOT_FOUND;
                        state_in  = ST_REPLY;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_REM_CMP;
                     end
                  end
                  KIND_SHOW: begin
                     if (list_empty) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_REPLY;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_SHOW_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INS_CMP: begin
            if (rd_ge) begin
               if (idx_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  idx_in = idx_dec;
               end
            end else begin
               count_in  = count_ff + CNT_W'(1);
               status_in = STAT_OK;
               state_in  = ST_REPLY;
            end
         end
         ST_INS_PUT: begin
            count_in  = count_ff + CNT_W'(1);
            status_in = STAT_OK;
            state_in  = ST_REPLY;
         end
         ST_REM_CMP: begin
            if (rd_eq) begin
               found_in = 1'b1;
            end
            if (at_last) begin
               if (found_ff || rd_eq) begin
                  count_in  = count_dec;
                  status_in = STAT_OK;
               end else begin
                  status_in = STAT_NOT_FOUND;
               end
               state_in = ST_REPLY;
            end else begin
               idx_in = idx_inc;
            end
         end
         ST_SHOW_RD: begin
            state_in = ST_SHOW_OUT;
         end
         ST_SHOW_OUT: begin
            if (out_free) begin
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = ST_SHOW_RD;
               end
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory control and result register loading
   always_comb begin
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = value_ff;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff;
      rsp_load      = 1'b0;
      rsp_item_in   = '0;
      rsp_status_in = status_ff;
      rsp_last_in   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_INSERT && !list_full && list_empty) begin
               ram_we    = 1'b1;
               ram_waddr = '0;
               ram_wdata = req_tdata;
            end
            // top entry for insert, bottom entry for remove
            if (accept && req_kind == KIND_INSERT && !list_full && !list_empty) begin
               ram_re    = 1'b1;
               ram_raddr = last_idx;
            end
            if (accept && req_kind == KIND_REMOVE && !list_empty) begin
               ram_re    = 1'b1;
               ram_raddr = '0;
            end
         end
         ST_INS_CMP: begin
            // move the entry up, or drop the value above the first smaller entry
            ram_we    = 1'b1;
            ram_waddr = idx_inc;
            ram_wdata = rd_ge ? ram_rdata : value_ff;
            if (rd_ge && idx_ff != '0) begin
               ram_re    = 1'b1;
               ram_raddr = idx_dec;
            end
         end
         ST_INS_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = value_ff;
         end
         ST_REM_CMP: begin
            // behind the match every entry slides down one slot
            if (found_ff) begin
               ram_we    = 1'b1;
               ram_waddr = idx_dec;
               ram_wdata = ram_rdata;
            end
            if (!at_last) begin
               ram_re    = 1'b1;
               ram_raddr = idx_inc;
            end
         end
         ST_SHOW_RD: begin
            ram_re    = 1'b1;
            ram_raddr = idx_ff;
         end
         ST_SHOW_OUT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_item_in   = ram_rdata;
               rsp_status_in = STAT_OK;
               rsp_last_in   = at_last;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_load = 1'b1;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // result register valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      if (rsp_load) begin
         rsp_item_ff   <= rsp_item_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_item_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### tb/tb_sorted_list_insert_remove_core.sv
// self-checking testbench for sorted_list_insert_remove_core
// depends on slist_pkg and the core; predicts each transfer from a queue-based list model
// runs directed corner cases, fill/drain sequences and random traffic with random stalls
module tb_sorted_list_insert_remove_core;
   import slist_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CAPACITY    = SLIST_CAPACITY;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;           // kind code the core ignores
   localparam int          CYCLE_LIMIT = 500000;
   localparam int          DRAIN_WAIT  = 2 * CAPACITY + 8;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   // one expected result transfer
   typedef struct {
      logic signed [31:0] item;
      status_type         status;
      logic               last;
   } list_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic [1:0]  req_tuser  = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] item, [33:32] status, zero above
   logic        rsp_tlast;

   // list contents as the core should hold them, ascending
   logic signed [31:0] sorted_values[$];
   // results still owed by the core, oldest first
   list_result_type    pending_results[$];

   int  errors       = 0;
   int  cycle_count  = 0;
   int  stall_left   = 0;
   bit  quiet        = 1'b0;   // no idling on either side when set

   sorted_list_insert_remove_core #(
      .CAPACITY (CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit, in case the core hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $realtime, CYCLE_LIMIT);
         $display("tb_sorted_list_insert_remove_core: FAIL");
         $finish;
      end
   end

   // result side backpressure: random stall bursts of random length
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // apply one request to the list model and queue the results it owes
   function automatic void predict_list_op(input logic [1:0] kind,
                                           input logic signed [31:0] value);
      int pos;
      int i;
      list_result_type res;
      res.item   = '0;
      res.status = STAT_OK;
      res.last   = 1'b1;
      case (kind)
         KIND_INSERT: begin
            if (sorted_values.size() >= CAPACITY) begin
               // full list: insert dropped
               res.status = STAT_FULL;
            end else begin
               // goes in front of the first entry that is >= value
               pos = sorted_values.size();
               for (i = 0; i < sorted_values.size(); i++) begin
                  if (sorted_values[i] >= value) begin
                     pos = i;
                     break;
                  end
               end
               sorted_values.insert(pos, value);
            end
            pending_results.push_back(res);
         end
         KIND_REMOVE: begin
            pos = -1;
            for (i = 0; i < sorted_values.size(); i++) begin
               if (sorted_values[i] == value) begin
                  pos = i;
                  break;
               end
            end
            if (pos < 0) res.status = STAT_NOT_FOUND;
            else         sorted_values.delete(pos);
            pending_results.push_back(res);
         end
         KIND_SHOW: begin
            if (sorted_values.size() == 0) begin
               res.status = STAT_EMPTY;
               pending_results.push_back(res);
            end else begin
               for (i = 0; i < sorted_values.size(); i++) begin
                  res.item = sorted_values[i];
                  res.last = (i == sorted_values.size() - 1);
                  pending_results.push_back(res);
               end
            end
         end
         default: ;   // unused kind: no change, no result
      endcase
   endfunction

   // result checker: every accepted transfer against the oldest expectation
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got item %0d status %0d last %0b",
                     $realtime, $signed(rsp_tdata[31:0]), rsp_tdata[33:32], rsp_tlast);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.item) begin
               $display("%0t: item mismatch: expected %0d, got %0d",
                        $realtime, want.item, $signed(rsp_tdata[31:0]));
               errors++;
            end
            if (rsp_tdata[33:32] !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $realtime, want.status, rsp_tdata[33:32]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last mismatch: expected %0b, got %0b",
                        $realtime, want.last, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[39:34] !== 6'd0) begin
               $display("%0t: pad bits mismatch: expected 0, got %0h",
                        $realtime, rsp_tdata[39:34]);
               errors++;
            end
         end
      end
   end

   // one request transfer, with an optional idle burst before it
   task automatic send_request(input logic [1:0] kind, input logic signed [31:0] value);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predict_list_op(kind, value);
   endtask

   // mostly small values so duplicates and hits are common
   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 7);
      case (sel)
         0:       return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0:       return VAL_MIN;
               1:       return VAL_MAX;
               2:       return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom_range(0, 15)) - 32'sd8;
      endcase
   endfunction

   // removes usually name a value that is present
   function automatic logic signed [31:0] pick_remove_value();
      if (sorted_values.size() != 0 && $urandom_range(0, 3) != 0)
         return sorted_values[$urandom_range(0, sorted_values.size() - 1)];
      return pick_value();
   endfunction

   // empty list, extremes, duplicates, absent values, unused kind
   task automatic test_directed();
      send_request(KIND_SHOW,   32'sd0);      // empty list result
      send_request(KIND_REMOVE, 32'sd5);      // remove from empty list
      send_request(KIND_UNUSED, 32'sh5a5a_a5a5);
      send_request(KIND_INSERT, VAL_MAX);
      send_request(KIND_INSERT, VAL_MIN);
      send_request(KIND_INSERT, 32'sd0);
      send_request(KIND_INSERT, 32'sd0);      // duplicate kept
      send_request(KIND_INSERT, -32'sd1);
      send_request(KIND_INSERT, 32'sd1);
      send_request(KIND_SHOW,   32'sh7fff_ffff);
      send_request(KIND_REMOVE, 32'sd7);      // absent value
      send_request(KIND_REMOVE, 32'sd0);      // first of two equal entries
      send_request(KIND_REMOVE, VAL_MAX);
      send_request(KIND_REMOVE, VAL_MIN);
      send_request(KIND_UNUSED, 32'sd0);
      send_request(KIND_SHOW,   32'sd0);
      send_request(KIND_REMOVE, 32'sd0);
      send_request(KIND_REMOVE, -32'sd1);
      send_request(KIND_REMOVE, 32'sd1);
      send_request(KIND_SHOW,   32'sd0);      // empty again
   endtask

   // fill past capacity, show the full list, then empty it in random order
   task automatic test_fill_and_drain();
      int i;
      for (i = 0; i < CAPACITY + 3; i++)
         send_request(KIND_INSERT, pick_value());
      send_request(KIND_SHOW, $urandom);
      while (sorted_values.size() != 0) begin
         if ($urandom_range(0, 5) == 0) send_request(KIND_REMOVE, $urandom);
         else send_request(KIND_REMOVE, sorted_values[$urandom_range(0, sorted_values.size() - 1)]);
      end
      send_request(KIND_SHOW, $urandom);
   endtask

   // random mix, alternating between growing and shrinking the list
   task automatic test_random_mix(input int count);
      int i;
      int roll;
      bit grow;
      for (i = 0; i < count; i++) begin
         grow = ((i / 40) % 2) == 0;
         roll = $urandom_range(0, 99);
         if (roll < 4)
            send_request(KIND_UNUSED, $urandom);
         else if (roll < 18)
            send_request(KIND_SHOW, $urandom);
         else if (roll < (grow ? 75 : 35))
            send_request(KIND_INSERT, pick_value());
         else
            send_request(KIND_REMOVE, pick_remove_value());
      end
   endtask

   // closing stretch with both sides running flat out
   task automatic test_back_to_back(input int count);
      quiet = 1'b1;
      test_random_mix(count);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_drain();
      test_random_mix(180);
      test_fill_and_drain();
      test_back_to_back(40);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // let any stray result show up
      repeat (DRAIN_WAIT) @(posedge clock);

      if (errors == 0) begin
         $display("tb_sorted_list_insert_remove_core: PASS");
      end else begin
         $display("tb_sorted_list_insert_remove_core: FAIL");
      end
      $finish;
   end

endmodule

### sorted_list_insert_remove_core.f
rtl/slist_pkg.sv
rtl/slist_ram.sv
rtl/sorted_list_insert_remove_core.sv
tb/tb_sorted_list_insert_remove_core.sv
